### rtl/diff_drive_profile_tracker_defines.svh
// ----------------------------------------------------------------------------
// diff drive profile tracker assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_PROFILE_TRACKER_DEFINES_SVH
`define DIFF_DRIVE_PROFILE_TRACKER_DEFINES_SVH

// consequent holds in the next cycle
`define DDPT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ddpt next-cycle check failed");

// consequent holds in the same cycle
`define DDPT_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ddpt same-cycle check failed");

`endif

### rtl/ddpt_pkg.sv
// ----------------------------------------------------------------------------
// ddpt_pkg
// types and constants of the differential drive profile tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ddpt_pkg;

  localparam int PADDR_W = 5;

  localparam logic [6:0]  HALF_TIME_CAP = 7'd100;
  localparam logic [8:0]  HOLD_TICKS    = 9'd15;
  localparam logic [16:0] PWM_TOP       = 17'd1999;

  // register indexes
  localparam logic [2:0] REG_LIN_ACCEL    = 3'd0;
  localparam logic [2:0] REG_TURN_ACCEL   = 3'd1;
  localparam logic [2:0] REG_LIN_GAIN     = 3'd2;
  localparam logic [2:0] REG_ANG_GAIN     = 3'd3;
  localparam logic [2:0] REG_COUNTS_TO_CM = 3'd4;
  localparam logic [2:0] REG_CM_TO_ANGLE  = 3'd5;

  // opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // shared multiplier operand widths
  localparam int MUL_AW = 51;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] distance;
    logic signed [15:0] angle;
    logic [15:0]        right_count;
    logic [15:0]        left_count;
  } in_t;

  typedef struct packed {
    logic [10:0] right_duty;
    logic        right_forward;
    logic [10:0] left_duty;
    logic        left_forward;
    logic        preset_encoders;
    logic        moving;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] lin_accel;
    logic [15:0] turn_accel;
    logic [15:0] lin_gain;
    logic [15:0] ang_gain;
    logic [15:0] counts_to_cm;
    logic [15:0] cm_to_angle;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/diff_drive_profile_tracker.sv
// ----------------------------------------------------------------------------
// diff_drive_profile_tracker
// triangular profile follower with proportional wheel control
// ----------------------------------------------------------------------------
//  channel   signals                              transfer when
//  in        in_valid in_stall in_data            in_valid && !in_stall
//  out       out_valid out_stall out_data         out_valid && !out_stall
//  cfg       psel penable pwrite paddr pwdata     psel && penable && pwrite
//
//  start item: 7-bit half time search, one bit per pass through S_HSQ, S_HACC and S_HCMP
//  tick item: states S_PR to S_DF through the shared multiplier, idle tick goes straight to S_OUT
//  one extra transfer for the stop result at the end of a profile
//  in_stall stays high from acceptance until the last result is taken
//  synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_profile_tracker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire ddpt_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output ddpt_pkg::out_t                    out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ddpt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import ddpt_pkg::*;

  cfg_t                     cfg;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p_r;

  ddpt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ddpt_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p_r (mul_p_r)
  );

  ddpt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_p     (mul_p_r)
  );

endmodule

`default_nettype wire

### rtl/ddpt_mul.sv
// ----------------------------------------------------------------------------
// ddpt_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module ddpt_mul (
  input  wire logic                                 clk,
  input  wire logic signed [ddpt_pkg::MUL_AW-1:0]   mul_a,
  input  wire logic signed [ddpt_pkg::MUL_BW-1:0]   mul_b,
  output logic signed [ddpt_pkg::MUL_PW-1:0]        mul_p_r
);
  import ddpt_pkg::*;

  always_ff @(posedge clk) begin
    mul_p_r <= MUL_PW'(mul_a) * MUL_PW'(mul_b);
  end

endmodule

`default_nettype wire

### rtl/ddpt_cfg.sv
// ----------------------------------------------------------------------------
// ddpt_cfg
// apb register file for accelerations, gains and scales
// ----------------------------------------------------------------------------
`default_nettype none

module ddpt_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ddpt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output ddpt_pkg::cfg_t                    cfg
);
  import ddpt_pkg::*;

  cfg_t        cfg_r;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lin_accel    <= 16'd655;
      cfg_r.turn_accel   <= 16'd655;
      cfg_r.lin_gain     <= 16'd4096;
      cfg_r.ang_gain     <= 16'd4096;
      cfg_r.counts_to_cm <= 16'd16;
      cfg_r.cm_to_angle  <= 16'd256;
    end else if (wr_en) begin
      unique case (idx)
        REG_LIN_ACCEL:    cfg_r.lin_accel    <= pwdata[15:0];
        REG_TURN_ACCEL:   cfg_r.turn_accel   <= pwdata[15:0];
        REG_LIN_GAIN:     cfg_r.lin_gain     <= pwdata[15:0];
        REG_ANG_GAIN:     cfg_r.ang_gain     <= pwdata[15:0];
        REG_COUNTS_TO_CM: cfg_r.counts_to_cm <= pwdata[15:0];
        REG_CM_TO_ANGLE:  cfg_r.cm_to_angle  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LIN_ACCEL:    prdata = {16'd0, cfg_r.lin_accel};
      REG_TURN_ACCEL:   prdata = {16'd0, cfg_r.turn_accel};
      REG_LIN_GAIN:     prdata = {16'd0, cfg_r.lin_gain};
      REG_ANG_GAIN:     prdata = {16'd0, cfg_r.ang_gain};
      REG_COUNTS_TO_CM: prdata = {16'd0, cfg_r.counts_to_cm};
      REG_CM_TO_ANGLE:  prdata = {16'd0, cfg_r.cm_to_angle};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ddpt_core.sv
// ----------------------------------------------------------------------------
// ddpt_core
// sequencer and datapath around one shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module ddpt_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ddpt_pkg::in_t                       in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output ddpt_pkg::out_t                           out_data,
  input  wire ddpt_pkg::cfg_t                      cfg,
  output logic signed [ddpt_pkg::MUL_AW-1:0]       mul_a,
  output logic signed [ddpt_pkg::MUL_BW-1:0]       mul_b,
  input  wire logic signed [ddpt_pkg::MUL_PW-1:0]  mul_p
);
  import ddpt_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_HSQ  = 16'h0002,
    S_HACC = 16'h0004,
    S_HCMP = 16'h0008,
    S_PR   = 16'h0010,
    S_PL   = 16'h0020,
    S_HD   = 16'h0040,
    S_TT   = 16'h0080,
    S_RR   = 16'h0100,
    S_LIN  = 16'h0200,
    S_ANG  = 16'h0400,
    S_CMD  = 16'h0800,
    S_DR   = 16'h1000,
    S_DL   = 16'h2000,
    S_DF   = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [55:0] q);
    logic signed [31:0] res;
    if (q > 56'sh0000_0000_7FFF_FFFF) res = 32'sh7FFF_FFFF;
    else if (q < -56'sh0000_0000_8000_0000) res = -32'sh8000_0000;
    else res = q[31:0];
    return res;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = 33'(v);
    return v[31] ? 33'(-w) : 33'(w);
  endfunction

  function automatic logic [16:0] wmag(input logic signed [32:0] v);
    logic [16:0] res;
    if (v >= 33'sd65536 || v <= -33'sd65536) res = 17'd65536;
    else if (v[32]) res = 17'(-v);
    else res = v[16:0];
    return res;
  endfunction

  state_t state_r, state_nxt;
  logic   active_r;

  logic               straight_r;
  logic [6:0]         h_r;
  logic [2:0]         bit_r;
  logic [15:0]        x_r;
  logic [7:0]         step_r;
  logic signed [15:0] tgt_d_r, tgt_a_r;
  logic signed [31:0] held_lin_r, held_ang_r;
  logic [15:0]        rcnt_r, lcnt_r;
  logic signed [32:0] pr_r, pl_r;
  logic signed [41:0] head_r;
  logic signed [42:0] err_a_r;
  logic signed [31:0] lin_r;
  logic signed [32:0] rc_r, lc_r;
  logic               end_r;
  logic [10:0]        rduty_r;
  out_t               out_r;

  logic               acc_ok;
  logic [6:0]         hcand;
  logic [15:0]        acc_sel;
  logic               in_xfer, out_xfer;
  logic signed [33:0] pdiff;
  logic [7:0]         h2;
  logic               reg0, reg1;
  logic [7:0]         m;
  logic [30:0]        rr;
  logic signed [15:0] tx;
  logic signed [32:0] sr;
  logic signed [33:0] prof, full;
  logic signed [32:0] mean;
  logic signed [34:0] err_l;
  logic signed [42:0] err_a;
  logic signed [31:0] ang_c;
  logic               hold, adv;
  logic signed [32:0] rc_c, lc_c;
  logic [8:0]         t_nxt, len;
  logic               end_c;
  logic [15:0]        x_in;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign out_xfer  = out_valid && !out_stall;
  assign out_data  = out_r;

  assign hcand   = h_r | (7'd1 << bit_r);
  assign acc_sel = straight_r ? cfg.lin_accel : cfg.turn_accel;
  assign acc_ok  = (hcand <= HALF_TIME_CAP) &&
                   (mul_p <= $signed(MUL_PW'({x_r, 16'd0})));

  assign pdiff = 34'($signed(mul_p[32:0])) - 34'(pr_r);

  assign h2   = {h_r, 1'b0};
  assign reg0 = step_r < {1'b0, h_r};
  assign reg1 = step_r < h2;
  assign m    = reg0 ? step_r : (reg1 ? 8'(h2 - 8'd1 - step_r) : 8'd0);

  assign rr   = mul_p[31:1];
  assign tx   = straight_r ? tgt_d_r : tgt_a_r;
  assign sr   = tx[15] ? -$signed({2'b00, rr}) : ((tx != 16'sd0) ? $signed({2'b00, rr}) : 33'sd0);
  assign full = 34'($signed({tx, 16'd0}));
  assign prof = reg0 ? 34'(sr) : (reg1 ? full - 34'(sr) : full);
  assign mean = 33'((34'(pl_r) + 34'(pr_r)) >>> 1);
  assign err_l = (straight_r ? 35'(prof) : 35'sd0) - 35'(mean);
  assign err_a = (straight_r ? 43'sd0 : 43'(prof)) - 43'(head_r);

  assign ang_c = sat32($signed(mul_p[67:12]));
  assign hold  = (step_r == {1'b0, h_r});
  assign len   = {1'b0, h2} + HOLD_TICKS;
  assign x_in  = (in_data.angle == 16'sd0) ?
                 (in_data.distance[15] ? 16'(-in_data.distance) : in_data.distance) :
                 (in_data.angle[15] ? 16'(-in_data.angle) : in_data.angle);

  always_comb begin
    rc_c = 33'(lin_r) - 33'(ang_c);
    lc_c = 33'(lin_r) + 33'(ang_c);
    adv  = 1'b1;
    if (hold) begin
      if (straight_r) begin
        rc_c = 33'(held_lin_r) - 33'(ang_c);
        lc_c = 33'(held_lin_r) + 33'(ang_c);
        adv  = mag33(lin_r) <= mag33(held_lin_r);
      end else begin
        rc_c = 33'(lin_r) - 33'(held_ang_r);
        lc_c = 33'(lin_r) + 33'(held_ang_r);
        adv  = mag33(ang_c) <= mag33(held_ang_r);
      end
    end
    t_nxt = {1'b0, step_r} + {8'd0, adv};
    end_c = t_nxt >= len;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_HSQ: begin
        mul_a = $signed(MUL_AW'(hcand));
        mul_b = $signed(MUL_BW'(hcand));
      end
      S_HACC: begin
        mul_a = MUL_AW'(mul_p);
        mul_b = $signed(MUL_BW'(acc_sel));
      end
      S_PR: begin
        mul_a = MUL_AW'($signed({~rcnt_r[15], rcnt_r[14:0]}));
        mul_b = $signed(MUL_BW'(cfg.counts_to_cm));
      end
      S_PL: begin
        mul_a = MUL_AW'($signed({~lcnt_r[15], lcnt_r[14:0]}));
        mul_b = $signed(MUL_BW'(cfg.counts_to_cm));
      end
      S_HD: begin
        mul_a = MUL_AW'(pdiff);
        mul_b = $signed(MUL_BW'(cfg.cm_to_angle));
      end
      S_TT: begin
        mul_a = $signed(MUL_AW'(m));
        mul_b = $signed(MUL_BW'(m));
      end
      S_RR: begin
        mul_a = $signed(MUL_AW'(mul_p[15:0]));
        mul_b = $signed(MUL_BW'(acc_sel));
      end
      S_LIN: begin
        mul_a = MUL_AW'(err_l);
        mul_b = $signed(MUL_BW'(cfg.lin_gain));
      end
      S_ANG: begin
        mul_a = MUL_AW'(err_a_r);
        mul_b = $signed(MUL_BW'(cfg.ang_gain));
      end
      S_DR: begin
        mul_a = $signed(MUL_AW'(wmag(rc_r)));
        mul_b = $signed(PWM_TOP);
      end
      S_DL: begin
        mul_a = $signed(MUL_AW'(wmag(lc_r)));
        mul_b = $signed(PWM_TOP);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.opcode == OP_START) state_nxt = S_HSQ;
          else if (active_r) state_nxt = S_PR;
          else state_nxt = S_OUT;
        end
      end
      S_HSQ:  state_nxt = S_HACC;
      S_HACC: state_nxt = S_HCMP;
      S_HCMP: state_nxt = (bit_r == 3'd0) ? S_OUT : S_HSQ;
      S_PR:   state_nxt = S_PL;
      S_PL:   state_nxt = S_HD;
      S_HD:   state_nxt = S_TT;
      S_TT:   state_nxt = S_RR;
      S_RR:   state_nxt = S_LIN;
      S_LIN:  state_nxt = S_ANG;
      S_ANG:  state_nxt = S_CMD;
      S_CMD:  state_nxt = S_DR;
      S_DR:   state_nxt = S_DL;
      S_DL:   state_nxt = S_DF;
      S_DF:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_xfer && !end_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer && in_data.opcode == OP_START) active_r <= 1'b1;
      else if (state_r == S_CMD && end_c) active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.opcode == OP_START) begin
            straight_r <= (in_data.angle == 16'sd0);
            tgt_d_r    <= in_data.distance;
            tgt_a_r    <= in_data.angle;
            x_r        <= x_in;
            h_r        <= 7'd0;
            bit_r      <= 3'd6;
            step_r     <= 8'd0;
            held_lin_r <= 32'sd0;
            held_ang_r <= 32'sd0;
          end else begin
            rcnt_r <= in_data.right_count;
            lcnt_r <= in_data.left_count;
            // stop result, kept only for a tick with no move running
            end_r  <= 1'b0;
            out_r  <= '{right_duty: 11'd0, right_forward: 1'b1, left_duty: 11'd0,
                        left_forward: 1'b1, preset_encoders: 1'b0, moving: 1'b0,
                        last: 1'b1};
          end
        end
      end
      S_HCMP: begin
        if (acc_ok) h_r <= hcand;
        bit_r <= bit_r - 3'd1;
        end_r <= 1'b0;
        out_r <= '{right_duty: 11'd0, right_forward: 1'b1, left_duty: 11'd0,
                   left_forward: 1'b1, preset_encoders: 1'b1, moving: 1'b1,
                   last: 1'b1};
      end
      S_PL:  pr_r    <= $signed(mul_p[32:0]);
      S_HD:  pl_r    <= $signed(mul_p[32:0]);
      S_TT:  head_r  <= $signed(mul_p[49:8]);
      S_LIN: err_a_r <= err_a;
      S_ANG: lin_r   <= sat32($signed(mul_p[67:12]));
      S_CMD: begin
        if (!hold) begin
          held_lin_r <= lin_r;
          held_ang_r <= ang_c;
        end
        step_r <= t_nxt[7:0];
        rc_r   <= rc_c;
        lc_r   <= lc_c;
        end_r  <= end_c;
      end
      S_DL: rduty_r <= mul_p[26:16];
      S_DF: begin
        out_r <= '{right_duty: rduty_r, right_forward: !rc_r[32],
                   left_duty: mul_p[26:16], left_forward: !lc_r[32],
                   preset_encoders: 1'b0, moving: 1'b1, last: !end_r};
      end
      S_OUT: begin
        // stop result after the profile ends
        if (out_xfer && end_r) begin
          end_r <= 1'b0;
          out_r <= '{right_duty: 11'd0, right_forward: 1'b1, left_duty: 11'd0,
                     left_forward: 1'b1, preset_encoders: 1'b0, moving: 1'b0,
                     last: 1'b1};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ddpt_checker.sv
// ----------------------------------------------------------------------------
// ddpt_checker
// port level checks on the tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "diff_drive_profile_tracker_defines.svh"

module ddpt_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire ddpt_pkg::out_t out_data
);
  import ddpt_pkg::*;

  `DDPT_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)
  `DDPT_ASSERT_SAME(a_no_in_while_out, clk, rst_n, out_valid, in_stall)
  `DDPT_ASSERT_NEXT(a_stop_follows, clk, rst_n, out_valid && !out_stall && !out_data.last, out_valid && out_data.last && !out_data.moving)
  `DDPT_ASSERT_SAME(a_preset_start, clk, rst_n, out_valid && out_data.preset_encoders, out_data.last && out_data.moving)
  `DDPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind diff_drive_profile_tracker ddpt_checker u_ddpt_checker (.*);

`default_nettype wire
